>>> src/ptts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_pkg
// shared widths, codes and the result word type of the periodic task scheduler
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int MAX_TASKS_DEF = 8;

  localparam int OP_W    = 2;
  localparam int CD_W    = 16;
  localparam int IDXIN_W = 3;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  localparam logic [KIND_W-1:0] K_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] K_FAULT   = 3'd1;
  localparam logic [KIND_W-1:0] K_DUE     = 3'd2;
  localparam logic [KIND_W-1:0] K_NONE    = 3'd3;
  localparam logic [KIND_W-1:0] K_STATS   = 3'd4;
  localparam logic [KIND_W-1:0] K_IGNORED = 3'd5;

  localparam logic [FAULT_W-1:0] F_NONE   = 2'd0;
  localparam logic [FAULT_W-1:0] F_FULL   = 2'd1;
  localparam logic [FAULT_W-1:0] F_PERIOD = 2'd2;

  localparam logic [CD_W-1:0]   CD_MAX    = 16'hFFFF;
  localparam logic [TIME_W-1:0] TIME_ONES = 32'hFFFFFFFF;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  task_slot;
    logic [FAULT_W-1:0] fault_code;
    logic               last;
    logic [TIME_W-1:0]  runs;
    logic [TIME_W-1:0]  best_seen;
    logic [TIME_W-1:0]  worst_seen;
  } res_t;

endpackage
`default_nettype wire

>>> src/periodic_task_table_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler
// table of periodic task slots with add, tick and run time report words
// ----------------------------------------------------------------------------
// One word is taken at a time. Countdown and period of each slot live in one
// memory, run count and best and worst times in another; slot occupancy is
// kept in flip-flops. An add walks the slots one per cycle looking for a free
// one; a zero period is refused at once. A tick reads every slot in turn and
// writes the new countdown back to each used one, holding on a slot that falls
// due while the result stream stalls. A report is a read, modify and write of
// the statistics memory, which is not touched when the slot is not in use.
// Results wait in an output register, so the next word is taken while the
// last result of the previous one is still pending.
// ----------------------------------------------------------------------------
module periodic_task_table_scheduler
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // start_delay[15:0], task_period[31:16], slot_index[34:32], measured_time[66:35]
  input  wire logic [71:0]  s_tdata,
  // op[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // task_slot[3:0], fault_code[5:4], runs[37:6], best_seen[69:38], worst_seen[101:70]
  output logic [103:0]      m_tdata,
  // kind[2:0]
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TIM_W  = 2 * CD_W;
  localparam int STAT_W = 3 * TIME_W;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_TASKS - 1);
  localparam logic [SLOT_W-1:0] NO_SLOT  = SLOT_W'(MAX_TASKS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EMIT     = 3'd1;
  localparam logic [2:0] S_ADD      = 3'd2;
  localparam logic [2:0] S_TICK_RD  = 3'd3;
  localparam logic [2:0] S_TICK_WB  = 3'd4;
  localparam logic [2:0] S_TICK_END = 3'd5;
  localparam logic [2:0] S_RPT_RD   = 3'd6;
  localparam logic [2:0] S_RPT_WB   = 3'd7;

  logic [2:0]           state;
  logic [IDX_W-1:0]     idx;
  logic [MAX_TASKS-1:0] used;
  logic                 pend_v;
  logic [IDX_W-1:0]     pend_slot;
  res_t                 res;
  logic [CD_W-1:0]      delay_q;
  logic [CD_W-1:0]      period_q;
  logic [TIME_W-1:0]    meas_q;

  logic [1:0]           in_op;
  logic [CD_W-1:0]      in_delay;
  logic [CD_W-1:0]      in_period;
  logic [IDXIN_W-1:0]   in_slot;
  logic [TIME_W-1:0]    in_meas;
  logic                 in_acc;
  logic                 rpt_ok;

  logic                 tim_we;
  logic [TIM_W-1:0]     tim_wdata;
  logic                 tim_re;
  logic [TIM_W-1:0]     tim_rdata;
  logic                 stat_we;
  logic [STAT_W-1:0]    stat_wdata;
  logic                 stat_re;
  logic [STAT_W-1:0]    stat_rdata;

  logic                 emit_valid;
  res_t                 emit_word;
  logic                 can_emit;
  res_t                 out_word;

  logic [CD_W-1:0]      cd_cur;
  logic [CD_W-1:0]      cd_per;
  logic [CD_W-1:0]      cd_dec;
  logic                 tick_due;
  logic                 tick_go;
  logic [TIME_W-1:0]    st_runs;
  logic [TIME_W-1:0]    st_best;
  logic [TIME_W-1:0]    st_worst;
  logic [CD_W-1:0]      cd_load;

  assign in_op     = s_tuser;
  assign in_delay  = s_tdata[15:0];
  assign in_period = s_tdata[31:16];
  assign in_slot   = s_tdata[34:32];
  assign in_meas   = s_tdata[66:35];
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign rpt_ok    = (7'(in_slot) < 7'(MAX_TASKS)) && used[IDX_W'(in_slot)];

  assign cd_cur   = tim_rdata[CD_W-1:0];
  assign cd_per   = tim_rdata[TIM_W-1:CD_W];
  assign cd_dec   = cd_cur - 1'b1;
  assign tick_due = used[idx] && (cd_dec == '0);
  assign tick_go  = !(tick_due && pend_v && !can_emit);
  assign cd_load  = (delay_q == CD_MAX) ? CD_MAX : delay_q + 1'b1;

  assign st_runs  = stat_rdata[TIME_W-1:0] + 1'b1;
  assign st_best  = (meas_q < stat_rdata[2*TIME_W-1:TIME_W]) ? meas_q
                                                            : stat_rdata[2*TIME_W-1:TIME_W];
  assign st_worst = (meas_q > stat_rdata[STAT_W-1:2*TIME_W]) ? meas_q
                                                            : stat_rdata[STAT_W-1:2*TIME_W];

  ptts_ram #(
    .WIDTH (TIM_W),
    .DEPTH (MAX_TASKS)
  ) u_tim_ram (
    .clk   (clk),
    .we    (tim_we),
    .waddr (idx),
    .wdata (tim_wdata),
    .re    (tim_re),
    .raddr (idx),
    .rdata (tim_rdata)
  );

  ptts_ram #(
    .WIDTH (STAT_W),
    .DEPTH (MAX_TASKS)
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (idx),
    .wdata (stat_wdata),
    .re    (stat_re),
    .raddr (idx),
    .rdata (stat_rdata)
  );

  ptts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (emit_valid),
    .in_word   (emit_word),
    .in_ready  (can_emit),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tuser = out_word.kind;
  assign m_tlast = out_word.last;
  assign m_tdata = {2'b00, out_word.worst_seen, out_word.best_seen, out_word.runs,
                    out_word.fault_code, out_word.task_slot};

  // memory access and result selection
  always_comb begin
    tim_we     = 1'b0;
    tim_wdata  = {period_q, cd_load};
    tim_re     = 1'b0;
    stat_we    = 1'b0;
    stat_wdata = {TIME_W'(0), TIME_ONES, TIME_W'(0)};
    stat_re    = 1'b0;
    emit_valid = 1'b0;
    emit_word  = res;
    unique case (state)
      S_EMIT: begin
        emit_valid = 1'b1;
      end
      S_ADD: begin
        if (!used[idx]) begin
          tim_we  = 1'b1;
          stat_we = 1'b1;
        end
      end
      S_TICK_RD: begin
        tim_re = 1'b1;
      end
      S_TICK_WB: begin
        tim_we    = used[idx] && tick_go;
        tim_wdata = {cd_per, tick_due ? cd_per : cd_dec};
        emit_valid = tick_due && pend_v && can_emit;
        emit_word  = '{kind: K_DUE, task_slot: SLOT_W'(pend_slot), fault_code: F_NONE,
                       last: 1'b0, runs: '0, best_seen: '0, worst_seen: '0};
      end
      S_TICK_END: begin
        emit_valid = 1'b1;
        emit_word  = '{kind: pend_v ? K_DUE : K_NONE,
                       task_slot: pend_v ? SLOT_W'(pend_slot) : NO_SLOT,
                       fault_code: F_NONE, last: 1'b1,
                       runs: '0, best_seen: '0, worst_seen: '0};
      end
      S_RPT_RD: begin
        stat_re = 1'b1;
      end
      S_RPT_WB: begin
        stat_we    = 1'b1;
        stat_wdata = {st_worst, st_best, st_runs};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      pend_v <= 1'b0;
      idx    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pend_v   <= 1'b0;
            delay_q  <= in_delay;
            period_q <= in_period;
            meas_q   <= in_meas;
            unique case (in_op)
              OP_ADD: begin
                idx <= '0;
                if (in_period == '0) begin
                  res   <= '{kind: K_FAULT, task_slot: NO_SLOT, fault_code: F_PERIOD,
                             last: 1'b1, runs: '0, best_seen: '0, worst_seen: '0};
                  state <= S_EMIT;
                end else begin
                  state <= S_ADD;
                end
              end
              OP_TICK: begin
                idx   <= '0;
                state <= S_TICK_RD;
              end
              OP_REPORT: begin
                res   <= '{kind: K_IGNORED, task_slot: SLOT_W'(in_slot),
                           fault_code: F_NONE, last: 1'b1,
                           runs: '0, best_seen: '0, worst_seen: '0};
                idx   <= IDX_W'(in_slot);
                state <= rpt_ok ? S_RPT_RD : S_EMIT;
              end
              default: begin
                idx   <= '0;
                res   <= '{kind: K_IGNORED, task_slot: NO_SLOT, fault_code: F_NONE,
                           last: 1'b1, runs: '0, best_seen: '0, worst_seen: '0};
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        S_ADD: begin
          if (!used[idx]) begin
            used[idx] <= 1'b1;
            res       <= '{kind: K_ADDED, task_slot: SLOT_W'(idx), fault_code: F_NONE,
                           last: 1'b1, runs: '0, best_seen: '0, worst_seen: '0};
            state     <= S_EMIT;
          end else if (idx == IDX_LAST) begin
            res   <= '{kind: K_FAULT, task_slot: NO_SLOT, fault_code: F_FULL,
                       last: 1'b1, runs: '0, best_seen: '0, worst_seen: '0};
            state <= S_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TICK_RD: begin
          state <= S_TICK_WB;
        end
        S_TICK_WB: begin
          if (tick_go) begin
            if (tick_due) begin
              pend_v    <= 1'b1;
              pend_slot <= idx;
            end
            if (idx == IDX_LAST) begin
              state <= S_TICK_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_TICK_RD;
            end
          end
        end
        S_TICK_END: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        S_RPT_RD: begin
          state <= S_RPT_WB;
        end
        S_RPT_WB: begin
          res   <= '{kind: K_STATS, task_slot: res.task_slot, fault_code: F_NONE,
                     last: 1'b1, runs: st_runs, best_seen: st_best,
                     worst_seen: st_worst};
          state <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ptts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ptts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/ptts_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_out_reg
// output holding register between the sequencer and the result stream
// ----------------------------------------------------------------------------
module ptts_out_reg
  import ptts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire res_t in_word,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_word
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= in_word;
    end
  end

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking testbench of periodic_task_table_scheduler
// ----------------------------------------------------------------------------
// A directed table covers the empty table, ignored reports, the spare op,
// both add faults, the delay extremes and a full table. Random tick, report,
// add and spare words follow under three idle mixes, with one long output stall
// and one drain pause. Every result word is checked field by field against
// a scheduler model kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import ptts_pkg::*;

  localparam int NTASK = MAX_TASKS_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NTASK);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP = 60;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CD_W-1:0]    start_delay;
    logic [CD_W-1:0]    task_period;
    logic [IDXIN_W-1:0] slot_index;
    logic [TIME_W-1:0]  measured_time;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  // scheduler model state
  logic              used_tbl      [NTASK];
  logic [CD_W-1:0]   countdown_tbl [NTASK];
  logic [CD_W-1:0]   period_tbl    [NTASK];
  logic [TIME_W-1:0] runs_tbl      [NTASK];
  logic [TIME_W-1:0] best_tbl      [NTASK];
  logic [TIME_W-1:0] worst_tbl     [NTASK];

  res_t     pending_results [$];
  res_t     step_results [$];
  dir_row_t dir_rows [DIR_ROWS];

  int errors = 0;
  int words_in = 0;
  int results_out = 0;
  int releases_seen = 0;
  int stats_seen = 0;
  int faults_seen = 0;
  int idle_ticks_seen = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  logic hold_taken = 1'b0;

  periodic_task_table_scheduler uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
                                  input logic [SLOT_W-1:0] slot,
                                  input logic [FAULT_W-1:0] fault,
                                  input logic [TIME_W-1:0] runs,
                                  input logic [TIME_W-1:0] best,
                                  input logic [TIME_W-1:0] worst);
    res_t r;
    r.kind       = kind;
    r.task_slot  = slot;
    r.fault_code = fault;
    r.last       = 1'b0;
    r.runs       = runs;
    r.best_seen  = best;
    r.worst_seen = worst;
    return r;
  endfunction

  function automatic dir_row_t row(input logic [OP_W-1:0] op,
                                   input logic [CD_W-1:0] dly,
                                   input logic [CD_W-1:0] per,
                                   input logic [IDXIN_W-1:0] idx,
                                   input logic [TIME_W-1:0] meas,
                                   input logic typed,
                                   input res_t want);
    dir_row_t d;
    d.cmd.op            = op;
    d.cmd.start_delay   = dly;
    d.cmd.task_period   = per;
    d.cmd.slot_index    = idx;
    d.cmd.measured_time = meas;
    d.typed             = typed;
    d.want              = want;
    d.want.last         = 1'b1;
    return d;
  endfunction

  // releases, stats and faults for one accepted word
  task automatic predict_schedule(input cmd_t c);
    int free_slot;
    logic [IDXIN_W-1:0] idx;
    free_slot = NTASK;
    idx = c.slot_index;
    case (c.op)
      OP_ADD: begin
        for (int i = NTASK - 1; i >= 0; i--) if (!used_tbl[i]) free_slot = i;
        if (c.task_period == '0) begin
          step_results.push_back(mk_res(K_FAULT, NO_SLOT, F_PERIOD, '0, '0, '0));
        end else if (free_slot == NTASK) begin
          step_results.push_back(mk_res(K_FAULT, NO_SLOT, F_FULL, '0, '0, '0));
        end else begin
          used_tbl[free_slot]      = 1'b1;
          countdown_tbl[free_slot] = (c.start_delay == CD_MAX) ? CD_MAX
                                                               : c.start_delay + 1'b1;
          period_tbl[free_slot]    = c.task_period;
          runs_tbl[free_slot]      = '0;
          best_tbl[free_slot]      = TIME_ONES;
          worst_tbl[free_slot]     = '0;
          step_results.push_back(mk_res(K_ADDED, SLOT_W'(free_slot), F_NONE, '0, '0, '0));
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NTASK; i++) begin
          if (used_tbl[i]) begin
            countdown_tbl[i] = countdown_tbl[i] - 1'b1;
            if (countdown_tbl[i] == '0) begin
              countdown_tbl[i] = period_tbl[i];
              step_results.push_back(mk_res(K_DUE, SLOT_W'(i), F_NONE, '0, '0, '0));
            end
          end
        end
        if (step_results.size() == 0)
          step_results.push_back(mk_res(K_NONE, NO_SLOT, F_NONE, '0, '0, '0));
      end
      OP_REPORT: begin
        if (used_tbl[idx]) begin
          runs_tbl[idx] = runs_tbl[idx] + 1'b1;
          if (c.measured_time < best_tbl[idx]) best_tbl[idx] = c.measured_time;
          if (c.measured_time > worst_tbl[idx]) worst_tbl[idx] = c.measured_time;
          step_results.push_back(mk_res(K_STATS, SLOT_W'(idx), F_NONE, runs_tbl[idx],
                                        best_tbl[idx], worst_tbl[idx]));
        end else begin
          step_results.push_back(mk_res(K_IGNORED, SLOT_W'(idx), F_NONE, '0, '0, '0));
        end
      end
      default: begin
        step_results.push_back(mk_res(K_IGNORED, NO_SLOT, F_NONE, '0, '0, '0));
      end
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) c.op = OP_TICK;
    else if (pick < 85) c.op = OP_REPORT;
    else if (pick < 97) c.op = OP_ADD;
    else c.op = OP_SPARE;
    c.start_delay = CD_W'($urandom_range(65534));
    c.task_period = ($urandom_range(3) == 0) ? '0 : CD_W'($urandom_range(65535, 1));
    c.slot_index  = IDXIN_W'($urandom_range(NTASK - 1));
    case ($urandom_range(9))
      0: c.measured_time = '0;
      1: c.measured_time = TIME_ONES;
      default: c.measured_time = $urandom;
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // valid is left high after a word so back-to-back words need one update
  task automatic send_word(input cmd_t c, input logic typed, input res_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {5'b0, c.measured_time, c.slot_index, c.task_period, c.start_delay};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    step_results.delete();
    predict_schedule(c);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[k]) pending_results.push_back(step_results[k]);
    words_in++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_directed();
    dir_rows[0]  = row(OP_TICK, 16'd0, 16'd0, 3'd0, 32'd0, 1'b1,
                       mk_res(K_NONE, NO_SLOT, F_NONE, '0, '0, '0));
    dir_rows[1]  = row(OP_REPORT, 16'd0, 16'd0, 3'd0, 32'd5, 1'b1,
                       mk_res(K_IGNORED, 4'd0, F_NONE, '0, '0, '0));
    dir_rows[2]  = row(OP_REPORT, 16'd0, 16'd0, 3'd7, TIME_ONES, 1'b1,
                       mk_res(K_IGNORED, 4'd7, F_NONE, '0, '0, '0));
    dir_rows[3]  = row(OP_SPARE, 16'd0, 16'd0, 3'd0, 32'd0, 1'b1,
                       mk_res(K_IGNORED, NO_SLOT, F_NONE, '0, '0, '0));
    dir_rows[4]  = row(OP_ADD, 16'd5, 16'd0, 3'd0, 32'd0, 1'b1,
                       mk_res(K_FAULT, NO_SLOT, F_PERIOD, '0, '0, '0));
    dir_rows[5]  = row(OP_ADD, 16'd0, 16'd2, 3'd0, 32'd0, 1'b1,
                       mk_res(K_ADDED, 4'd0, F_NONE, '0, '0, '0));
    dir_rows[6]  = row(OP_ADD, CD_MAX, CD_MAX, 3'd0, 32'd0, 1'b1,
                       mk_res(K_ADDED, 4'd1, F_NONE, '0, '0, '0));
    dir_rows[7]  = row(OP_ADD, 16'd65534, 16'd1, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[8]  = row(OP_TICK, 16'd0, 16'd0, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[9]  = row(OP_TICK, 16'd0, 16'd0, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[10] = row(OP_REPORT, 16'd0, 16'd0, 3'd0, 32'd0, 1'b1,
                       mk_res(K_STATS, 4'd0, F_NONE, 32'd1, 32'd0, 32'd0));
    dir_rows[11] = row(OP_REPORT, 16'd0, 16'd0, 3'd0, TIME_ONES, 1'b1,
                       mk_res(K_STATS, 4'd0, F_NONE, 32'd2, 32'd0, TIME_ONES));
    dir_rows[12] = row(OP_REPORT, 16'd0, 16'd0, 3'd1, 32'd1234, 1'b0, '0);
    dir_rows[13] = row(OP_ADD, 16'd1, 16'd3, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[14] = row(OP_ADD, 16'd2, 16'd5, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[15] = row(OP_ADD, 16'd0, 16'd1, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[16] = row(OP_ADD, 16'd3, 16'd7, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[17] = row(OP_TICK, 16'd0, 16'd0, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[18] = row(OP_ADD, 16'd0, 16'd4, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[19] = row(OP_ADD, 16'd9, 16'd9, 3'd0, 32'd0, 1'b1,
                       mk_res(K_FAULT, NO_SLOT, F_FULL, '0, '0, '0));
    dir_rows[20] = row(OP_ADD, 16'd0, 16'd0, 3'd0, 32'd0, 1'b1,
                       mk_res(K_FAULT, NO_SLOT, F_PERIOD, '0, '0, '0));
    dir_rows[21] = row(OP_TICK, 16'd0, 16'd0, 3'd0, 32'd0, 1'b0, '0);
    dir_rows[22] = row(OP_REPORT, 16'd0, 16'd0, 3'd6, 32'hAAAAAAAA, 1'b0, '0);
    dir_rows[23] = row(OP_REPORT, 16'd0, 16'd0, 3'd3, 32'h55555555, 1'b0, '0);
    dir_rows[24] = row(OP_TICK, 16'd0, 16'd0, 3'd0, 32'd0, 1'b0, '0);
  endtask

  // result side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_out++;
      case (m_tuser)
        K_DUE:   releases_seen++;
        K_STATS: stats_seen++;
        K_FAULT: faults_seen++;
        K_NONE:  idle_ticks_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, kind", 32'(m_tuser), 32'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(m_tuser), 32'(want.kind));
        check_field("task_slot", 32'(m_tdata[3:0]), 32'(want.task_slot));
        check_field("fault_code", 32'(m_tdata[5:4]), 32'(want.fault_code));
        check_field("runs", m_tdata[37:6], want.runs);
        check_field("best_seen", m_tdata[69:38], want.best_seen);
        check_field("worst_seen", m_tdata[101:70], want.worst_seen);
        check_field("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NTASK; i++) begin
      used_tbl[i]  = 1'b0;
      runs_tbl[i]  = '0;
      best_tbl[i]  = TIME_ONES;
      worst_tbl[i] = '0;
    end
    load_directed();
    src_idle_pct  <= 28;
    sink_idle_pct <= 80;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_word(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);
    repeat (85) send_word(rand_cmd(), 1'b0, '0);
    wait_drained();

    src_idle_pct  <= 80;
    sink_idle_pct <= 28;
    repeat (85) send_word(rand_cmd(), 1'b0, '0);

    // no idling; hold the result side off while words keep coming
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    hold_start    <= 1'b1;
    repeat (85) send_word(rand_cmd(), 1'b0, '0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words in and %0d results out: %0d releases, %0d stats",
             words_in, results_out, releases_seen, stats_seen);
    $display("  %0d add faults, %0d ticks with nothing due, %0d mismatches",
             faults_seen, idle_ticks_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
